@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the converter RTL.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/fpcm_pkg.sv @@
// Package for the float/PCM sample converter: codes and types.
// Depends on nothing.
package fpcm_pkg;
    localparam logic [1:0] RES_8  = 2'd0;
    localparam logic [1:0] RES_16 = 2'd1;
    localparam logic [1:0] RES_24 = 2'd2;
    localparam logic [1:0] RES_32 = 2'd3;
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic [31:0] word;
        logic        clipped;
    } fpcm_result_t;
endpackage

@@ hw/rtl/fpcm_convert.sv @@
// Combinational float/PCM conversion of one sample.
// Depends on fpcm_pkg.
module fpcm_convert
    import fpcm_pkg::*;
(
    input  logic         command,
    input  logic [1:0]   resolution,
    input  logic [31:0]  sample_word,
    output fpcm_result_t result
);
    logic        sgn;
    logic [7:0]  exp_f;
    logic [22:0] man;
    logic [4:0]  nbits;
    logic [23:0] mag_full;
    logic [47:0] shifted;
    logic [23:0] ipart;
    logic        frac_nz;
    logic [24:0] mag_floor;
    logic [24:0] lim_pos;
    logic        is_nan;
    logic        ovf;
    logic [24:0] code;
    logic [24:0] dec_val;
    logic        dec_neg;
    logic [24:0] dec_mag;
    logic [4:0]  lz;
    logic [24:0] norm;
    logic [7:0]  dec_exp;
    logic [31:0] dec_bits;
    logic [7:0]  sh;
    logic [24:0] ip_neg;

    always_comb
    begin
        sgn   = sample_word[31];
        exp_f = sample_word[30:23];
        man   = sample_word[22:0];
        case (resolution)
            RES_8:   nbits = 5'd7;
            RES_16:  nbits = 5'd15;
            default: nbits = 5'd23;
        endcase
        lim_pos  = (25'd1 << nbits);
        is_nan   = (exp_f == 8'hFF) && (man != 23'd0);
        mag_full = {(exp_f != 8'd0), man};
        // value = mag_full * 2^(exp-150+nbits); integer part after shift
        shifted  = 48'd0;
        ipart    = 24'd0;
        frac_nz  = 1'b0;
        ovf      = 1'b0;
        sh       = 8'd0;
        if (exp_f == 8'hFF)
        begin
            ovf = 1'b1;
        end
        else if ({3'd0, exp_f} + {6'd0, nbits} >= 11'd150)
        begin
            sh = 8'(({3'd0, exp_f} + {6'd0, nbits}) - 11'd150);
            if (sh != 8'd0)
                ovf = 1'b1;
            else
                ipart = mag_full;
        end
        else
        begin
            sh = 8'(11'd150 - ({3'd0, exp_f} + {6'd0, nbits}));
            if (sh >= 8'd24)
            begin
                ipart   = 24'd0;
                frac_nz = (mag_full != 24'd0);
            end
            else
            begin
                shifted = {mag_full, 24'd0} >> sh;
                ipart   = shifted[47:24];
                frac_nz = (shifted[23:0] != 24'd0);
            end
        end
        // any left shift is past full scale; ipart always fits 24 bits
        mag_floor = {1'b0, ipart};
        ip_neg    = mag_floor + {24'd0, frac_nz};
        code      = 25'd0;
        result.clipped = 1'b0;
        if (is_nan)
        begin
            result.clipped = 1'b1;
            code = 25'd0;
        end
        else if (!sgn)
        begin
            if (ovf || mag_floor >= lim_pos)
            begin
                result.clipped = 1'b1;
                code = lim_pos - 25'd1;
            end
            else
                code = mag_floor;
        end
        else
        begin
            if (ovf || ip_neg > lim_pos)
            begin
                result.clipped = 1'b1;
                code = -lim_pos;
            end
            else
                code = -ip_neg;
        end

        // decode
        case (resolution)
            RES_8:   dec_val = {{17{sample_word[7]}}, sample_word[7:0]};
            RES_16:  dec_val = {{9{sample_word[15]}}, sample_word[15:0]};
            default: dec_val = {sample_word[15], sample_word[15:0], sample_word[23:16]};
        endcase
        dec_neg = dec_val[24];
        dec_mag = dec_neg ? -dec_val : dec_val;
        lz = 5'd0;
        for (int i = 0; i < 25; i++)
        begin
            if (dec_mag[i])
                lz = 5'(i);
        end
        norm    = dec_mag << (5'd24 - lz);
        dec_exp = 8'(8'd127 + {3'd0, lz} - {3'd0, nbits});
        if (dec_mag == 25'd0)
            dec_bits = 32'd0;
        else
            dec_bits = {dec_neg, dec_exp, norm[23:1]};

        if (resolution == RES_32)
        begin
            result.word    = sample_word;
            result.clipped = 1'b0;
        end
        else if (command == CMD_ENCODE)
        begin
            case (resolution)
                RES_8:   result.word = {24'd0, code[7:0]};
                RES_16:  result.word = {16'd0, code[15:0]};
                default: result.word = {8'd0, code[7:0], code[23:8]};
            endcase
        end
        else
        begin
            result.word    = dec_bits;
            result.clipped = 1'b0;
        end
    end
endmodule

@@ hw/rtl/float_pcm_sample_converter.sv @@
// Float/PCM sample converter top level.
// Path: the input register feeds fpcm_convert, whose output is captured in the result register.
// One transaction per cycle through the single conversion stage while out_stall does not hold it.
// Reset: asynchronous, active low; clears valids and sets resolution to 16 bits.
// Depends on fpcm_pkg, fpcm_convert, assert_macros.svh.
`include "assert_macros.svh"
module float_pcm_sample_converter
    import fpcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] sample_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_word,
    output logic        clipped
);
    logic [1:0]   resolution_reg;
    logic         a_valid_reg;
    logic         a_cmd_reg;
    logic [31:0]  a_word_reg;
    logic         b_valid_reg;
    fpcm_result_t b_res_reg;
    fpcm_result_t conv;
    logic         b_load;
    logic         a_load;

    fpcm_convert u_convert (
        .command     (a_cmd_reg),
        .resolution  (resolution_reg),
        .sample_word (a_word_reg),
        .result      (conv)
    );

    assign b_load   = !b_valid_reg || !out_stall;
    assign a_load   = !a_valid_reg || b_load;
    assign in_stall = !a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RES_16;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                resolution_reg <= cfg_wdata;
            if (a_load)
                a_valid_reg <= in_valid;
            if (b_load)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && in_valid)
        begin
            a_cmd_reg  <= command;
            a_word_reg <= sample_word;
        end
        if (b_load && a_valid_reg)
            b_res_reg <= conv;
    end

    assign out_valid   = b_valid_reg;
    assign result_word = b_res_reg.word;
    assign clipped     = b_res_reg.clipped;

    `ASSERT_NEXT(a_held_a, clk, rst_n, a_valid_reg && !b_load, a_valid_reg)
    `ASSERT_NEXT(b_held_a, clk, rst_n, out_valid && out_stall, out_valid && $stable(b_res_reg))
    `ASSERT_IMPLIES(stall_a, clk, rst_n, in_stall, a_valid_reg && b_valid_reg)
endmodule
